>>> hdl/dts_pkg.sv
// Shared constants and types for the depth-first topological sort block.
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int VERTEX_W         = 7;

    // Visit marks
    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic fetch;     // latch the accepted edge and read its list ends
        logic load;      // link the latched edge into its list
        logic root_rd;   // read mark/head of the root candidate
        logic root_push; // push the root candidate
        logic root_next; // advance the root candidate
        logic top_rd;    // read the stack top
        logic edge_rd;   // read the edge under the top cursor
        logic tgt_rd;    // read mark/head of the edge target
        logic tgt_push;  // push the edge target
        logic pop;       // finish the top vertex
        logic emit;      // send one result
        logic cycle;     // send the cycle result
        logic clr;       // clear one mark/head entry
        logic init;      // reset counters for a new graph
    } t_cmd;

    typedef struct packed {
        logic root_end;   // root candidate past the last vertex
        logic root_new;   // root candidate unvisited
        logic stack_empty;
        logic cur_nil;    // top cursor at list end
        logic tgt_path;   // target on path
        logic tgt_new;    // target unvisited and stack has room
        logic emit_end;   // last result being sent
        logic clr_end;    // last entry being cleared
    } t_sts;
endpackage
`default_nettype wire

>>> hdl/dts_ctrl.sv
// Controller state machine for the topological sort.
`timescale 1ns / 1ps
`default_nettype none
module dts_ctrl
    import dts_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,
    input  wire  i_has_edge,
    input  wire  i_last_edge,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_LOAD  = 11'b00000000010,
        S_CLR   = 11'b00000000100,
        S_ROOT  = 11'b00000001000,
        S_RDEC  = 11'b00000010000,
        S_TOP   = 11'b00000100000,
        S_EDGE  = 11'b00001000000,
        S_TGT   = 11'b00010000000,
        S_TDEC  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_CYC   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.fetch) r_last <= i_last_edge;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_has_edge) begin
                        o_cmd.fetch = 1'b1;
                        n_state = S_LOAD;
                    end else if (i_last_edge) begin
                        o_cmd.init = 1'b1;
                        n_state = S_ROOT;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (r_last) begin
                    o_cmd.init = 1'b1;
                    n_state = S_ROOT;
                end else n_state = S_IDLE;
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_end) n_state = S_IDLE;
            end
            S_ROOT: begin
                if (i_sts.root_end) n_state = S_EMIT;
                else begin
                    o_cmd.root_rd = 1'b1;
                    n_state = S_RDEC;
                end
            end
            S_RDEC: begin
                if (i_sts.root_new) begin
                    o_cmd.root_push = 1'b1;
                    n_state = S_TOP;
                end else n_state = S_ROOT;
                o_cmd.root_next = 1'b1;
            end
            S_TOP: begin
                if (i_sts.stack_empty) n_state = S_ROOT;
                else begin
                    o_cmd.top_rd = 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (i_sts.cur_nil) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_TOP;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                o_cmd.tgt_rd = 1'b1;
                n_state = S_TDEC;
            end
            S_TDEC: begin
                if (i_sts.tgt_path) n_state = S_CYC;
                else begin
                    o_cmd.tgt_push = i_sts.tgt_new;
                    n_state = S_TOP;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_end) n_state = S_CLR;
            end
            S_CYC: begin
                o_cmd.cycle = 1'b1;
                n_state = S_CLR;
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

>>> hdl/dts_dp.sv
// Datapath: edge store, list heads and tails, marks, path stack and finish order.
`timescale 1ns / 1ps
`default_nettype none
module dts_dp
    import dts_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    input  wire [VERTEX_W-1:0]   i_num_vertices,
    input  wire [VERTEX_W-1:0]   i_from_vertex,
    input  wire [VERTEX_W-1:0]   i_to_vertex,
    output t_sts                 o_sts,
    output logic                 o_strobe,
    output logic [VERTEX_W-1:0]  o_vertex_number,
    output logic                 o_cycle_found,
    output logic                 o_edges_dropped,
    output logic                 o_last
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_EDGES + 1); // cursor with nil = MAX_EDGES
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NW = (VERTEX_W > CW) ? VERTEX_W : CW;
    localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

    // memories
    logic [VW-1:0] m_target [MAX_EDGES];
    logic [EW-1:0] m_next   [MAX_EDGES];
    logic [EW-1:0] m_head   [MAX_VERTICES];
    logic [EW-1:0] m_tail   [MAX_VERTICES];
    logic [1:0]    m_mark   [MAX_VERTICES];
    logic [VW-1:0] m_pvert  [MAX_VERTICES];
    logic [EW-1:0] m_pcur   [MAX_VERTICES];
    logic [VW-1:0] m_fin    [MAX_VERTICES];

    logic [EW-1:0] r_ecount;
    logic          r_drop;
    logic [CW-1:0] r_n, r_root, r_depth, r_done, r_ecnt, r_clr;
    logic [VW-1:0] r_top_v, r_tgt;
    logic [EW-1:0] r_top_c, r_head_rd, r_nxt;
    logic [1:0]    r_mark_rd;
    logic [VW-1:0] r_src_ld;
    logic          r_ok_ld;
    logic [EW-1:0] r_head_ld, r_tail_ld;

    // vertex limit
    logic [NW-1:0] nv;
    logic [CW-1:0] n_lim;
    always_comb begin
        nv = NW'(i_num_vertices);
        if (nv == '0) n_lim = CW'(1);
        else if (nv > NW'(MAX_VERTICES)) n_lim = CW'(MAX_VERTICES);
        else n_lim = CW'(nv);
    end

    // edge validity at load
    logic [NW-1:0] fv, tv;
    logic          e_ok;
    logic [VW-1:0] s_idx, t_idx;
    assign fv = NW'(i_from_vertex);
    assign tv = NW'(i_to_vertex);
    assign e_ok = (fv != '0) && (fv <= NW'(n_lim)) && (tv != '0) && (tv <= NW'(n_lim))
                  && (r_ecount < NIL);
    assign s_idx = VW'(fv - NW'(1));
    assign t_idx = VW'(tv - NW'(1));

    logic [AW-1:0] e_addr, c_addr;
    logic [VW-1:0] sp;
    assign e_addr = r_ecount[AW-1:0];
    assign c_addr = r_top_c[AW-1:0];
    assign sp     = VW'(r_depth - CW'(1));

    // edge store and lists
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && e_ok) begin
            m_target[e_addr] <= t_idx;
            m_next[e_addr]   <= NIL;
        end
        if (i_cmd.load && r_ok_ld) begin
            if (r_head_ld == NIL) m_head[r_src_ld] <= r_ecount;
            else m_next[r_tail_ld[AW-1:0]] <= r_ecount;
            m_tail[r_src_ld] <= r_ecount;
        end
        if (i_cmd.clr) begin
            m_head[r_clr[VW-1:0]] <= NIL;
            m_mark[r_clr[VW-1:0]] <= MARK_NEW;
        end
        if (i_cmd.root_push) begin
            m_mark[r_root[VW-1:0]] <= MARK_PATH;
            m_pvert[r_depth[VW-1:0]] <= r_root[VW-1:0];
            m_pcur[r_depth[VW-1:0]]  <= r_head_rd;
        end
        if (i_cmd.tgt_push) begin
            m_mark[r_tgt] <= MARK_PATH;
            m_pvert[r_depth[VW-1:0]] <= r_tgt;
            m_pcur[r_depth[VW-1:0]]  <= r_head_rd;
        end
        // advance the top cursor past the edge just read
        if (i_cmd.tgt_rd) m_pcur[sp] <= r_nxt;
        if (i_cmd.pop) begin
            m_mark[r_top_v] <= MARK_DONE;
            m_fin[r_done[VW-1:0]] <= r_top_v;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_src_ld  <= s_idx;
            r_ok_ld   <= e_ok;
            r_head_ld <= m_head[s_idx];
            r_tail_ld <= m_tail[s_idx];
        end
        if (i_cmd.top_rd) begin
            r_top_v <= m_pvert[sp];
            r_top_c <= m_pcur[sp];
        end
        if (i_cmd.edge_rd) begin
            r_tgt <= m_target[c_addr];
            r_nxt <= m_next[c_addr];
        end
        if (i_cmd.root_rd) begin
            r_mark_rd <= m_mark[r_root[VW-1:0]];
            r_head_rd <= m_head[r_root[VW-1:0]];
        end
        if (i_cmd.tgt_rd) begin
            r_mark_rd <= m_mark[r_tgt];
            r_head_rd <= m_head[r_tgt];
        end
        o_vertex_number <= VERTEX_W'(m_fin[VW'(r_ecnt - CW'(1))]) + VERTEX_W'(1);
        if (i_cmd.cycle) o_vertex_number <= '0;
        o_cycle_found   <= i_cmd.cycle;
        o_edges_dropped <= r_drop;
        o_last          <= i_cmd.cycle || (r_ecnt == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecount <= '0; r_drop <= 1'b0; r_n <= CW'(1); r_root <= '0;
            r_depth <= '0; r_done <= '0; r_ecnt <= '0; r_clr <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit || i_cmd.cycle;
            if (i_cmd.load && !r_ok_ld) r_drop <= 1'b1;
            if (i_cmd.load && r_ok_ld) r_ecount <= r_ecount + EW'(1);
            if (i_cmd.init) begin
                r_n <= n_lim; r_root <= '0; r_depth <= '0; r_done <= '0;
                r_ecnt <= n_lim;
            end
            if (i_cmd.root_next) r_root <= r_root + CW'(1);
            if (i_cmd.root_push || i_cmd.tgt_push) r_depth <= r_depth + CW'(1);
            if (i_cmd.pop) begin
                r_depth <= r_depth - CW'(1);
                r_done  <= r_done + CW'(1);
            end
            if (i_cmd.emit) r_ecnt <= r_ecnt - CW'(1);
            if (i_cmd.clr) begin
                r_clr <= (r_clr == CW'(MAX_VERTICES - 1)) ? '0 : r_clr + CW'(1);
                if (r_clr == CW'(MAX_VERTICES - 1)) begin
                    r_ecount <= '0;
                    r_drop   <= 1'b0;
                end
            end
        end
    end

    assign o_sts.root_end    = (r_root >= r_n);
    assign o_sts.root_new    = (r_mark_rd == MARK_NEW);
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.cur_nil     = (r_top_c >= NIL);
    assign o_sts.tgt_path    = (r_mark_rd == MARK_PATH);
    assign o_sts.tgt_new     = (r_mark_rd == MARK_NEW) && (r_depth < CW'(MAX_VERTICES));
    assign o_sts.emit_end    = (r_ecnt == CW'(1));
    assign o_sts.clr_end     = (r_clr == CW'(MAX_VERTICES - 1));
endmodule
`default_nettype wire

>>> hdl/dfs_topological_sort.sv
// Top level of the depth-first topological sort with cycle detection.
`timescale 1ns / 1ps
`default_nettype none
// Items are taken on start while busy is low. An item that carries an edge
// holds busy high while the edge is linked into its source list; a bare item
// without i_last_edge leaves busy low. An item with i_last_edge starts the
// search, which for each edge passes through a stack read, an edge read, a
// mark read and a decision, and for each vertex through a root check, a pop
// and one empty-stack check per root; the stack, edge and mark memories are
// read through registers. Results then appear one per cycle on o_strobe (the
// receiver cannot stall), in reverse finish order, or as one cycle result. A
// clearing pass over all MAX_VERTICES mark and head entries follows each graph
// and reset; busy stays high then.
module dfs_topological_sort
    import dts_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [VERTEX_W-1:0]  i_cfg_wdata,
    input  wire                 start,
    output logic                busy,
    input  wire [VERTEX_W-1:0]  i_from_vertex,
    input  wire [VERTEX_W-1:0]  i_to_vertex,
    input  wire                 i_has_edge,
    input  wire                 i_last_edge,
    output logic                o_strobe,
    output logic [VERTEX_W-1:0] o_vertex_number,
    output logic                o_cycle_found,
    output logic                o_edges_dropped,
    output logic                o_last
);
    logic [VERTEX_W-1:0] r_num_vertices;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_num_vertices <= VERTEX_W'(1);
        else if (i_cfg_we) r_num_vertices <= i_cfg_wdata;
    end

    dts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_has_edge(i_has_edge), .i_last_edge(i_last_edge),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    dts_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_num_vertices(r_num_vertices), .i_from_vertex(i_from_vertex),
        .i_to_vertex(i_to_vertex), .o_sts(sts), .o_strobe(o_strobe),
        .o_vertex_number(o_vertex_number), .o_cycle_found(o_cycle_found),
        .o_edges_dropped(o_edges_dropped), .o_last(o_last)
    );

    a_cycle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_cycle_found |-> o_last && o_vertex_number == '0)
        else $error("cycle result malformed");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cmd.emit) |-> o_strobe)
        else $error("emit lost");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> busy)
        else $error("last result while idle");
endmodule
`default_nettype wire
